[src/multilevel_ready_wait_task_scheduler_top_defines.svh]
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the scheduler.
// -----------------------------------------------------------------------------
`ifndef MULTILEVEL_READY_WAIT_TASK_SCHEDULER_TOP_DEFINES_SVH
`define MULTILEVEL_READY_WAIT_TASK_SCHEDULER_TOP_DEFINES_SVH

// plain property on clk_i, off during reset
`define MRW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("scheduler assertion failed");

// next-cycle implication
`define MRW_ASSERT_NEXT(lbl, ante, cons) \
  `MRW_ASSERT(lbl, (ante) |=> (cons))

`endif

[src/mrw_pkg.sv]
// -----------------------------------------------------------------------------
// Scheduler package
// Types, codes and defaults shared by the scheduler modules.
// -----------------------------------------------------------------------------
package mrw_pkg;

  localparam int MaxTasksDef = 128;
  localparam int LevelsDef   = 32;
  localparam logic [5:0] LevelsCfgReset = 6'd32;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_NEXT   = 2'd2;
  localparam logic [1:0] FUNC_RSVD   = 2'd3;

  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_ALREADY    = 3'd1;
  localparam logic [2:0] ST_NOT_QUEUED = 3'd2;
  localparam logic [2:0] ST_RANGE      = 3'd3;
  localparam logic [2:0] ST_EMPTY      = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_INFO, S_HTRD, S_WR, S_WR2, S_PICK, S_RESP
  } state_e;

  typedef struct packed {
    logic capture;
    logic eval;
    logic info;
    logic wr;
    logic wr2;
    logic pick;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       early;
    logic       list_ne;
    logic       out_free;
  } stat_t;

endpackage

[src/mrw_if.sv]
// -----------------------------------------------------------------------------
// Scheduler channels
// Request and response valid/ready channels.
// -----------------------------------------------------------------------------
interface mrw_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [6:0] task_id;
  logic [4:0] base_priority;
  logic [4:0] priority_boost;
  modport source (output valid, func, task_id, base_priority, priority_boost, input ready);
  modport sink (input valid, func, task_id, base_priority, priority_boost, output ready);
endinterface

interface mrw_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [6:0] chosen_task;
  logic       reloaded;
  modport source (output valid, status, chosen_task, reloaded, input ready);
  modport sink (input valid, status, chosen_task, reloaded, output ready);
endinterface

[src/multilevel_ready_wait_task_scheduler_top.sv]
// -----------------------------------------------------------------------------
// Multilevel ready/wait task scheduler
// Per-level ready and wait FIFOs with add, remove and next operations.
// -----------------------------------------------------------------------------
// One request is handled at a time. An error goes from evaluation to the
// response; next reads list head/tail, then picks; add, after a head/tail
// read if the list is non-empty, writes head/tail and links, then the task's
// link and list info; remove reads list info, then head/tail, then writes;
// the link and list head/tail memories have registered reads. A reload of
// every non-empty configured wait list swaps per-level list selectors. A new
// request is taken while a result still waits in the output register.
module multilevel_ready_wait_task_scheduler_top
  import mrw_pkg::*;
#(
  parameter int MAX_TASKS = MaxTasksDef,
  parameter int LEVELS    = LevelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mrw_req_if.sink     req,
  mrw_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [5:0] levels_q;
  cmd_t       cmd;
  stat_t      stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= LevelsCfgReset;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      levels_q <= pwdata[5:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = {26'd0, levels_q};

  mrw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mrw_datapath #(
    .MAX_TASKS (MAX_TASKS),
    .LEVELS    (LEVELS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .levels_cfg_i     (levels_q),
    .func_i           (req.func),
    .task_id_i        (req.task_id),
    .base_priority_i  (req.base_priority),
    .priority_boost_i (req.priority_boost),
    .out_valid_o      (rsp.valid),
    .out_ready_i      (rsp.ready),
    .status_o         (rsp.status),
    .chosen_task_o    (rsp.chosen_task),
    .reloaded_o       (rsp.reloaded)
  );

endmodule

[src/mrw_ctrl.sv]
// -----------------------------------------------------------------------------
// Scheduler controller
// Sequences each request through evaluation, memory reads and writes.
// -----------------------------------------------------------------------------
module mrw_ctrl
  import mrw_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (stat_i.early) begin
          state_d = S_RESP;
        end else begin
          case (stat_i.func)
            FUNC_ADD:    state_d = stat_i.list_ne ? S_HTRD : S_WR;
            FUNC_REMOVE: state_d = S_INFO;
            FUNC_NEXT:   state_d = S_HTRD;
            default:     state_d = S_RESP;
          endcase
        end
      end
      S_INFO: begin
        cmd_o.info = 1'b1;
        state_d    = S_HTRD;
      end
      S_HTRD: begin
        state_d = (stat_i.func == FUNC_NEXT) ? S_PICK : S_WR;
      end
      S_WR: begin
        cmd_o.wr = 1'b1;
        state_d  = (stat_i.func == FUNC_ADD) ? S_WR2 : S_RESP;
      end
      S_WR2: begin
        cmd_o.wr2 = 1'b1;
        state_d   = S_RESP;
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[src/mrw_datapath.sv]
// -----------------------------------------------------------------------------
// Scheduler datapath
// Link memories, list head/tail memory, level bitmaps and result register.
// -----------------------------------------------------------------------------
`include "multilevel_ready_wait_task_scheduler_top_defines.svh"

module mrw_datapath
  import mrw_pkg::*;
#(
  parameter int MAX_TASKS = MaxTasksDef,
  parameter int LEVELS    = LevelsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output stat_t      stat_o,
  input  logic [5:0] levels_cfg_i,
  input  logic [1:0] func_i,
  input  logic [6:0] task_id_i,
  input  logic [4:0] base_priority_i,
  input  logic [4:0] priority_boost_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [6:0] chosen_task_o,
  output logic       reloaded_o
);

  localparam int TW = $clog2(MAX_TASKS);
  localparam int LW = $clog2(LEVELS);
  localparam int NL = 2 * LEVELS;

  logic [1:0]    func_q;
  logic [6:0]    task_q;
  logic [5:0]    lvl_q;
  logic [LW:0]   list_q;
  logic [2:0]    status_q;
  logic [6:0]    chosen_q;
  logic          reloaded_q;
  logic          out_valid_q;
  logic [2:0]    out_status_q;
  logic [6:0]    out_chosen_q;
  logic          out_reloaded_q;

  logic [MAX_TASKS-1:0] queued_q;
  logic [LEVELS-1:0]    wsel_q;
  logic [NL-1:0]        ne_q;

  logic [TW-1:0]   next_mem [MAX_TASKS];
  logic [TW-1:0]   prev_mem [MAX_TASKS];
  logic [LW:0]     info_mem [MAX_TASKS];
  logic [2*TW-1:0] ht_mem   [NL];
  logic [TW-1:0]   next_rd_q, prev_rd_q;
  logic [LW:0]     info_rd_q;
  logic [2*TW-1:0] ht_rd_q;

  logic [6:0]    count;
  logic          t_ok;
  logic [TW-1:0] t_idx;
  logic [LW-1:0] add_lvl;
  logic [LW:0]   add_list;
  logic [LEVELS-1:0] rdy_vec, wt_vec;
  logic          top_hit, w_hit;
  logic [LW-1:0] top_lvl, w_lvl;
  logic [TW-1:0] ht_head, ht_tail;

  logic [2:0]    ev_status;
  logic          ev_reloaded;
  logic [LW:0]   ev_list;

  logic          next_we, prev_we, ht_we;
  logic [TW-1:0] next_wa, next_wd, prev_wa, prev_wd;
  logic [2*TW-1:0] ht_wd;

  assign count    = (int'(levels_cfg_i) < LEVELS) ? {1'b0, levels_cfg_i} : 7'(LEVELS);
  assign t_ok     = int'(task_q) < MAX_TASKS;
  assign t_idx    = TW'(task_q);
  assign add_lvl  = LW'(lvl_q);
  assign add_list = {add_lvl, wsel_q[add_lvl]};
  assign ht_head  = ht_rd_q[2*TW-1:TW];
  assign ht_tail  = ht_rd_q[TW-1:0];

  always_comb begin
    top_hit = 1'b0;
    w_hit   = 1'b0;
    top_lvl = '0;
    w_lvl   = '0;
    for (int i = 0; i < LEVELS; i++) begin
      rdy_vec[i] = ne_q[2*i + {31'd0, ~wsel_q[i]}] && (i < int'(count));
      wt_vec[i]  = ne_q[2*i + {31'd0, wsel_q[i]}] && (i < int'(count));
      if (rdy_vec[i]) begin
        top_hit = 1'b1;
        top_lvl = LW'(i);
      end
      if (wt_vec[i]) begin
        w_hit = 1'b1;
        w_lvl = LW'(i);
      end
    end
  end

  always_comb begin
    stat_o.func     = func_q;
    stat_o.list_ne  = ne_q[add_list];
    stat_o.out_free = !out_valid_q || out_ready_i;
    case (func_q)
      FUNC_ADD:    stat_o.early = !t_ok || queued_q[t_idx] || ({1'b0, lvl_q} >= count);
      FUNC_REMOVE: stat_o.early = !t_ok || !queued_q[t_idx];
      FUNC_NEXT:   stat_o.early = !top_hit && !w_hit;
      default:     stat_o.early = 1'b1;
    endcase
  end

  // evaluation result
  always_comb begin
    ev_status   = ST_DONE;
    ev_reloaded = 1'b0;
    ev_list     = add_list;
    case (func_q)
      FUNC_ADD: begin
        if (!t_ok) begin
          ev_status = ST_NOT_QUEUED;
        end else if (queued_q[t_idx]) begin
          ev_status = ST_ALREADY;
        end else if ({1'b0, lvl_q} >= count) begin
          ev_status = ST_RANGE;
        end
      end
      FUNC_REMOVE: begin
        if (!t_ok || !queued_q[t_idx]) begin
          ev_status = ST_NOT_QUEUED;
        end
      end
      FUNC_NEXT: begin
        if (top_hit) begin
          ev_list = {top_lvl, ~wsel_q[top_lvl]};
        end else if (w_hit) begin
          ev_list     = {w_lvl, wsel_q[w_lvl]};
          ev_reloaded = 1'b1;
        end else begin
          ev_status = ST_EMPTY;
        end
      end
      default: ev_status = ST_DONE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_q    <= '0;
      wsel_q      <= '0;
      ne_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.eval && func_q == FUNC_NEXT && !top_hit && w_hit) begin
        wsel_q <= wsel_q ^ wt_vec;
      end
      if (cmd_i.wr && func_q == FUNC_ADD) begin
        ne_q[list_q] <= 1'b1;
      end
      if (cmd_i.wr && func_q == FUNC_REMOVE) begin
        queued_q[t_idx] <= 1'b0;
        if (ht_head == t_idx && ht_tail == t_idx) begin
          ne_q[list_q] <= 1'b0;
        end
      end
      if (cmd_i.wr2) begin
        queued_q[t_idx] <= 1'b1;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      task_q <= task_id_i;
      lvl_q  <= {1'b0, base_priority_i} + {1'b0, priority_boost_i};
    end
    if (cmd_i.eval) begin
      chosen_q   <= '0;
      reloaded_q <= ev_reloaded;
      status_q   <= ev_status;
      list_q     <= ev_list;
    end
    if (cmd_i.info) begin
      list_q <= info_rd_q;
    end
    if (cmd_i.pick) begin
      chosen_q <= 7'(ht_head);
    end
    if (cmd_i.load) begin
      out_status_q   <= status_q;
      out_chosen_q   <= chosen_q;
      out_reloaded_q <= reloaded_q;
    end
  end

  always_comb begin
    next_we = 1'b0;
    prev_we = 1'b0;
    ht_we   = 1'b0;
    next_wa = t_idx;
    next_wd = t_idx;
    prev_wa = t_idx;
    prev_wd = t_idx;
    ht_wd   = {t_idx, t_idx};
    if (cmd_i.wr && func_q == FUNC_ADD) begin
      prev_we = 1'b1;
      ht_we   = 1'b1;
      if (ne_q[list_q]) begin
        next_we = 1'b1;
        next_wa = ht_tail;
        prev_wd = ht_tail;
        ht_wd   = {ht_head, t_idx};
      end
    end else if (cmd_i.wr && func_q == FUNC_REMOVE) begin
      ht_we   = 1'b1;
      next_wa = prev_rd_q;
      next_wd = next_rd_q;
      prev_wa = next_rd_q;
      prev_wd = prev_rd_q;
      next_we = (ht_head != t_idx);
      prev_we = (ht_tail != t_idx);
      ht_wd   = {(ht_head == t_idx) ? next_rd_q : ht_head,
                 (ht_tail == t_idx) ? prev_rd_q : ht_tail};
    end else if (cmd_i.wr2) begin
      next_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (cmd_i.wr2) begin
      info_mem[t_idx] <= list_q;
    end
    if (ht_we) begin
      ht_mem[list_q] <= ht_wd;
    end
    next_rd_q <= next_mem[t_idx];
    prev_rd_q <= prev_mem[t_idx];
    info_rd_q <= info_mem[t_idx];
    ht_rd_q   <= ht_mem[list_q];
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign chosen_task_o = out_chosen_q;
  assign reloaded_o    = out_reloaded_q;

  `MRW_ASSERT_NEXT(a_remove_clears, cmd_i.wr && func_q == FUNC_REMOVE, !queued_q[t_idx])
  `MRW_ASSERT_NEXT(a_add_sets, cmd_i.wr2, queued_q[t_idx] && ne_q[list_q])
  `MRW_ASSERT_NEXT(a_empty_zero, cmd_i.load && status_q == ST_EMPTY,
                   out_chosen_q == 7'd0 && !out_reloaded_q)

endmodule
